[sv/fifo_or_shortest_first_request_queue_macros.svh]
// Assertion helpers shared by the checker files.
`ifndef FIFO_OR_SHORTEST_FIRST_REQUEST_QUEUE_MACROS_SVH
`define FIFO_OR_SHORTEST_FIRST_REQUEST_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FOSFQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fosfq check failed");

// The consequent must hold in the cycle after the antecedent.
`define FOSFQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fosfq check failed");

`endif

[sv/fosfq_pkg.sv]
package fosfq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int LIMIT_W = 7;
   localparam int OCC_W = 7;
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int SMEAR_STEPS = $clog2(QUEUE_DEPTH);

   localparam int DESC_W = 16;
   localparam int TAG_W = 32;
   localparam int SIZE_W = 31;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [LIMIT_W-1:0] CAPACITY_RESET = 7'd64;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      ST_PUSHED = 2'd0,
      ST_FULL   = 2'd1,
      ST_POPPED = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLICY   = 1'b0,
      CSR_CAPACITY = 1'b1
   } csr_index_type;

   typedef enum logic {
      POLICY_FIFO     = 1'b0,
      POLICY_SHORTEST = 1'b1
   } policy_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_PREV,
      CELL_FROM_NEXT
   } cell_op_type;

   typedef struct packed {
      logic [DESC_W-1:0] descriptor;
      logic [TAG_W-1:0]  name_tag;
      logic [SIZE_W-1:0] size;
   } entry_type;

endpackage

[sv/fosfq_cell.sv]
module fosfq_cell (
   input  logic                   clock,
   input  fosfq_pkg::cell_op_type op,
   input  fosfq_pkg::entry_type   new_entry,
   input  fosfq_pkg::entry_type   prev_entry,
   input  fosfq_pkg::entry_type   next_entry,
   output fosfq_pkg::entry_type   entry,
   output logic                   greater
);
   import fosfq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      unique case (op)
         CELL_HOLD:      entry_in = entry_ff;
         CELL_LOAD:      entry_in = new_entry;
         CELL_FROM_PREV: entry_in = prev_entry;
         CELL_FROM_NEXT: entry_in = next_entry;
         default:        entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign greater = entry_ff.size > new_entry.size;

endmodule

[sv/fifo_or_shortest_first_request_queue.sv]
// Bounded request queue held in a row of 64 storage cells with the head in cell 0. Every beat
// is either a push or a pop and produces exactly one response beat in the cycle after it is taken,
// so one beat per cycle is sustained while the response side keeps up; the single response
// register sets that figure. A push in first-in first-out mode lands at the tail; in
// shortest-first mode every cell compares its size with the new one in parallel, the strictly
// larger tail entries step back one cell, and the new entry drops into the gap. A pop shifts
// every cell toward the head. Pushes beyond the capacity register (saturated at the depth) are
// rejected with a full status, pops of an empty queue return an empty status, and both leave
// the queue unchanged. The policy and capacity registers may be written at any time the queue
// is quiet.
module fifo_or_shortest_first_request_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [fosfq_pkg::DESC_W-1:0]        req_descriptor,
   input  logic [fosfq_pkg::TAG_W-1:0]         req_name_tag,
   input  logic [fosfq_pkg::SIZE_W-1:0]        req_request_size,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [fosfq_pkg::DESC_W-1:0]        rsp_out_descriptor,
   output logic [fosfq_pkg::TAG_W-1:0]         rsp_out_name_tag,
   output logic [fosfq_pkg::SIZE_W-1:0]        rsp_out_size,
   output logic [fosfq_pkg::OCC_W-1:0]         rsp_occupancy,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fosfq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fosfq_pkg::CSR_DATA_W-1:0]    csr_data
);
   import fosfq_pkg::*;

   logic                policy_ff;
   logic                policy_in;
   logic [LIMIT_W-1:0]  capacity_ff;
   logic [LIMIT_W-1:0]  capacity_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [1:0]          rsp_status_ff;
   logic [1:0]          rsp_status_in;
   entry_type           rsp_entry_ff;
   entry_type           rsp_entry_in;
   logic [OCC_W-1:0]    rsp_occupancy_ff;
   logic [OCC_W-1:0]    rsp_occupancy_in;
   logic [CMP_W-1:0]    occ_ext;

   logic                accept;
   logic                is_push;
   logic                full;
   logic                empty;
   logic                do_push;
   logic                do_pop;

   entry_type           new_entry;
   entry_type           cell_q [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] occupied;
   logic [QUEUE_DEPTH-1:0] greater;
   logic [QUEUE_DEPTH-1:0] stop;
   logic [QUEUE_DEPTH-1:0] stop_at_or_above;
   logic [QUEUE_DEPTH-1:0] move;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept = req_valid & ~req_stall;
   assign is_push = req_command == CMD_PUSH;
   assign empty = count_ff == '0;
   assign full = (CMP_W'(count_ff) >= CMP_W'(capacity_ff))
              || (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push = accept & is_push & ~full;
   assign do_pop = accept & ~is_push & ~empty;

   assign new_entry.descriptor = req_descriptor;
   assign new_entry.name_tag = req_name_tag;
   assign new_entry.size = req_request_size;

   // An occupied cell moves back only if it and every occupied cell behind it hold a
   // strictly larger size.
   always_comb begin
      logic [QUEUE_DEPTH-1:0] smear;
      smear = stop;
      for (int k = 0; k < SMEAR_STEPS; k++) begin
         smear = smear | (smear >> (1 << k));
      end
      stop_at_or_above = smear;
   end

   assign move = (policy_ff == POLICY_SHORTEST) ? (occupied & ~stop_at_or_above) : '0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_op_type cell_op;
      entry_type   prev_entry;
      entry_type   next_entry;
      logic        shift_in;
      logic        at_tail;

      if (i == 0) begin : g_head
         assign prev_entry = new_entry;
         assign shift_in = 1'b0;
      end else begin : g_body
         assign prev_entry = cell_q[i-1];
         assign shift_in = move[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_entry = cell_q[i];
      end else begin : g_inner
         assign next_entry = cell_q[i+1];
      end

      assign occupied[i] = CNT_W'(i) < count_ff;
      assign at_tail = CNT_W'(i) == count_ff;
      assign stop[i] = occupied[i] & ~greater[i];

      always_comb begin
         priority if (do_push && shift_in) begin
            cell_op = CELL_FROM_PREV;
         end else if (do_push && (move[i] || at_tail)) begin
            cell_op = CELL_LOAD;
         end else if (do_pop) begin
            cell_op = CELL_FROM_NEXT;
         end else begin
            cell_op = CELL_HOLD;
         end
      end

      fosfq_cell u_cell (
         .clock      (clock),
         .op         (cell_op),
         .new_entry  (new_entry),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (cell_q[i]),
         .greater    (greater[i])
      );
   end

   always_comb begin
      policy_in = policy_ff;
      capacity_in = capacity_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_POLICY:   policy_in = csr_data[0];
            CSR_CAPACITY: capacity_in = csr_data;
            default:      capacity_in = capacity_ff;
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      rsp_status_in = ST_PUSHED;
      rsp_entry_in = '0;
      if (is_push) begin
         if (full) begin
            rsp_status_in = ST_FULL;
         end else begin
            rsp_status_in = ST_PUSHED;
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (empty) begin
            rsp_status_in = ST_EMPTY;
         end else begin
            rsp_status_in = ST_POPPED;
            rsp_entry_in = cell_q[0];
            count_in = count_ff - CNT_W'(1);
         end
      end
      occ_ext = CMP_W'(count_in);
      rsp_occupancy_in = occ_ext[OCC_W-1:0];
      rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_FIFO;
         capacity_ff <= CAPACITY_RESET;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         policy_ff <= policy_in;
         capacity_ff <= capacity_in;
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_entry_ff <= rsp_entry_in;
         rsp_occupancy_ff <= rsp_occupancy_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_out_descriptor = rsp_entry_ff.descriptor;
   assign rsp_out_name_tag = rsp_entry_ff.name_tag;
   assign rsp_out_size = rsp_entry_ff.size;
   assign rsp_occupancy = rsp_occupancy_ff;

endmodule

[sv/fosfq_checker.sv]
`include "fifo_or_shortest_first_request_queue_macros.svh"

module fosfq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [1:0]                        rsp_status,
   input logic [fosfq_pkg::DESC_W-1:0]      rsp_out_descriptor,
   input logic [fosfq_pkg::TAG_W-1:0]       rsp_out_name_tag,
   input logic [fosfq_pkg::SIZE_W-1:0]      rsp_out_size,
   input logic [fosfq_pkg::OCC_W-1:0]       rsp_occupancy
);
   import fosfq_pkg::*;

   // A stalled response beat keeps its status and occupancy.
   `FOSFQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_occupancy))

   // Every request beat produces a response beat in the next cycle.
   `FOSFQ_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && !req_stall, rsp_valid)

   // Only a successful pop carries request data.
   `FOSFQ_ASSERT_SAME(a_data_zero, clock, reset, rsp_valid && (rsp_status == ST_PUSHED || rsp_status == ST_FULL || rsp_status == ST_EMPTY), rsp_out_descriptor == '0 && rsp_out_name_tag == '0 && rsp_out_size == '0)

   // An empty pop can only be reported with nothing queued.
   `FOSFQ_ASSERT_SAME(a_empty_occ, clock, reset, rsp_valid && rsp_status == ST_EMPTY, rsp_occupancy == '0)

endmodule

bind fifo_or_shortest_first_request_queue fosfq_checker u_fosfq_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_out_descriptor (rsp_out_descriptor),
   .rsp_out_name_tag   (rsp_out_name_tag),
   .rsp_out_size       (rsp_out_size),
   .rsp_occupancy      (rsp_occupancy)
);

[tb/fifo_or_shortest_first_request_queue_tb.sv]
module fifo_or_shortest_first_request_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fosfq_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      status_type        status;
      logic [DESC_W-1:0] descriptor;
      logic [TAG_W-1:0]  name_tag;
      logic [SIZE_W-1:0] size;
      logic [OCC_W-1:0]  occupancy;
   } response_type;

   class request_order_checker;
      entry_type    held[$];
      response_type pending[$];
      policy_type   policy;
      int unsigned  capacity;
      int           failures;

      function new();
         policy = POLICY_FIFO;
         capacity = CAPACITY_RESET;
         failures = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_POLICY) begin
            policy = policy_type'(data[0]);
         end else begin
            capacity = 32'(data);
         end
      endfunction

      function void take_request(command_type cmd, entry_type e);
         response_type r;
         entry_type    head;
         int           pos;
         int unsigned  room;
         r.descriptor = '0;
         r.name_tag = '0;
         r.size = '0;
         room = (capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : capacity;
         if (cmd == CMD_PUSH) begin
            if (held.size() >= room) begin
               r.status = ST_FULL;
            end else begin
               pos = held.size();
               if (policy == POLICY_SHORTEST) begin
                  while (pos > 0 && held[pos-1].size > e.size) pos--;
               end
               held.insert(pos, e);
               r.status = ST_PUSHED;
            end
         end else if (held.size() == 0) begin
            r.status = ST_EMPTY;
         end else begin
            head = held.pop_front();
            r.descriptor = head.descriptor;
            r.name_tag = head.name_tag;
            r.size = head.size;
            r.status = ST_POPPED;
         end
         r.occupancy = OCC_W'(held.size());
         pending.push_back(r);
      endfunction

      function void flag(string msg);
         if (failures < 10) $display("ERROR: %s", msg);
         failures++;
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) flag($sformatf("%s expected 0x%0h got 0x%0h", field, want, got));
      endfunction

      function void match_response(logic [1:0] st, logic [DESC_W-1:0] d,
                                   logic [TAG_W-1:0] t, logic [SIZE_W-1:0] s,
                                   logic [OCC_W-1:0] occ);
         response_type r;
         if (pending.size() == 0) begin
            flag("response beat arrived with none outstanding");
            return;
         end
         r = pending.pop_front();
         compare("status", 32'(r.status), 32'(st));
         compare("out_descriptor", 32'(r.descriptor), 32'(d));
         compare("out_name_tag", r.name_tag, t);
         compare("out_size", 32'(r.size), 32'(s));
         compare("occupancy", 32'(r.occupancy), 32'(occ));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_command;
   logic [DESC_W-1:0]     req_descriptor;
   logic [TAG_W-1:0]      req_name_tag;
   logic [SIZE_W-1:0]     req_request_size;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [1:0]            rsp_status;
   logic [DESC_W-1:0]     rsp_out_descriptor;
   logic [TAG_W-1:0]      rsp_out_name_tag;
   logic [SIZE_W-1:0]     rsp_out_size;
   logic [OCC_W-1:0]      rsp_occupancy;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   request_order_checker order_check = new();
   int  sender_idle = 34;
   int  receiver_idle = 80;
   bit  want_hold = 1'b0;
   int  quiet_cycles;

   fifo_or_shortest_first_request_queue dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_descriptor     (req_descriptor),
      .req_name_tag       (req_name_tag),
      .req_request_size   (req_request_size),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_out_descriptor (rsp_out_descriptor),
      .rsp_out_name_tag   (rsp_out_name_tag),
      .rsp_out_size       (rsp_out_size),
      .rsp_occupancy      (rsp_occupancy),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         order_check.match_response(rsp_status, rsp_out_descriptor, rsp_out_name_tag,
                                    rsp_out_size, rsp_occupancy);
      end
   end

   // The receiver stalls at random, or for a long unbroken stretch when asked.
   initial begin
      int held_cycles;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (want_hold) begin
            want_hold = 1'b0;
            for (held_cycles = 0; held_cycles < HOLD_CYCLES; held_cycles++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle);
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Mismatches found");
      $finish;
   end

   task automatic send_request(command_type cmd, logic [DESC_W-1:0] d,
                               logic [TAG_W-1:0] t, logic [SIZE_W-1:0] s);
      entry_type e;
      e = '{descriptor: d, name_tag: t, size: s};
      while ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_descriptor <= d;
      req_name_tag <= t;
      req_request_size <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      order_check.take_request(cmd, e);
   endtask

   task automatic random_request(int push_pct);
      command_type       cmd;
      logic [SIZE_W-1:0] sz;
      cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
      case ($urandom_range(9))
         0: sz = SIZE_W'($urandom());
         1: sz = '0;
         2: sz = '1;
         3: sz = SIZE_W'($urandom_range(100000, 1000));
         default: sz = SIZE_W'($urandom_range(15));
      endcase
      send_request(cmd, DESC_W'($urandom()), $urandom(), sz);
   endtask

   // Lets every outstanding response drain, then writes both registers back to back.
   task automatic reconfigure(policy_type p, logic [CSR_DATA_W-1:0] cap);
      logic [CSR_DATA_W-1:0] pol_word;
      req_valid <= 1'b0;
      while (order_check.pending.size() != 0) @(posedge clock);
      pol_word = CSR_DATA_W'($urandom_range(63) << 1);
      pol_word[0] = p;
      csr_valid <= 1'b1;
      csr_index <= CSR_POLICY;
      csr_data <= pol_word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      order_check.write_register(CSR_POLICY, pol_word);
      csr_index <= CSR_CAPACITY;
      csr_data <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      order_check.write_register(CSR_CAPACITY, cap);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(policy_type p, logic [CSR_DATA_W-1:0] cap, int push_pct,
                            int count);
      reconfigure(p, cap);
      repeat (count) random_request(push_pct);
   endtask

   initial begin
      logic [SIZE_W-1:0] mixed_sizes [6];
      int                k;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= CMD_PUSH;
      req_descriptor <= '0;
      req_name_tag <= '0;
      req_request_size <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_POLICY;
      csr_data <= '0;
      mixed_sizes = '{31'd5, 31'd3, 31'd5, 31'd0, '1, 31'd3};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_request(CMD_POP, '1, '1, '1);
      send_request(CMD_PUSH, '0, '0, '0);
      send_request(CMD_PUSH, '1, '1, '1);
      repeat (3) send_request(CMD_POP, '0, '0, '0);

      reconfigure(POLICY_SHORTEST, 7'd1);
      send_request(CMD_PUSH, 16'h1234, 32'hCAFE0001, 31'd9);
      send_request(CMD_PUSH, 16'h4321, 32'hCAFE0002, 31'd1);
      repeat (2) send_request(CMD_POP, '0, '0, '0);

      reconfigure(POLICY_FIFO, 7'd0);
      send_request(CMD_PUSH, 16'h00A5, 32'h5A5A5A5A, 31'd7);

      reconfigure(POLICY_SHORTEST, 7'd127);
      for (k = 0; k < 6; k++) begin
         send_request(CMD_PUSH, 16'(k + 1), 32'(k * 32'h01010101), mixed_sizes[k]);
      end
      repeat (6) send_request(CMD_POP, '0, '0, '0);

      run_phase(POLICY_SHORTEST, 7'd64, 75, 60);
      run_phase(POLICY_FIFO, 7'd5, 50, 40);
      run_phase(POLICY_SHORTEST, 7'd3, 50, 30);

      sender_idle = 80;
      receiver_idle = 34;
      run_phase(POLICY_FIFO, 7'd64, 70, 60);
      run_phase(POLICY_SHORTEST, 7'd64, 30, 60);
      run_phase(POLICY_FIFO, 7'd1, 50, 30);
      run_phase(POLICY_SHORTEST, 7'd0, 40, 20);

      sender_idle = 0;
      receiver_idle = 0;
      run_phase(POLICY_FIFO, 7'd100, 85, 80);
      run_phase(POLICY_SHORTEST, 7'd64, 100, 40);
      want_hold = 1'b1;
      repeat (30) random_request(60);
      run_phase(POLICY_FIFO, 7'd64, 20, 80);

      req_valid <= 1'b0;
      while (order_check.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (order_check.failures == 0 && order_check.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/fosfq_pkg.sv
sv/fosfq_cell.sv
sv/fifo_or_shortest_first_request_queue.sv
sv/fosfq_checker.sv
tb/fifo_or_shortest_first_request_queue_tb.sv
